@@ rtl/core/scc_pkg.sv @@
// scc_pkg: shared types and constants for the SCC labeler.
// Used by scc_ctrl, scc_dp and scc_labeler_unit; no dependencies.
package scc_pkg;
  localparam int MaxNodes = 16;
  localparam int NodeW    = 4;
  localparam int CntW     = 5;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCAN, S_STEP, S_POP, S_RET, S_EMIT
  } scc_state_t;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_RUN  = 1'b1
  } req_type_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;    // write adjacency row
    logic init;    // begin run
    logic start;   // next root candidate
    logic step;    // examine successor of top frame
    logic pop;     // pop one node into component
    logic ret;     // return from top frame
    logic emit;    // present next result
  } scc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic root_done;   // all roots scanned
    logic root_new;    // current root unvisited
    logic has_child;   // top frame has another successor
    logic is_head;     // top frame is component head
    logic pop_last;    // popped node equals top
    logic frame_empty; // frame stack empty after return
    logic emit_last;   // last result
  } scc_stat_t;
endpackage

@@ rtl/core/scc_labeler_unit.sv @@
// scc_labeler_unit: top level of the SCC labeler.
// Depends on scc_pkg, scc_ctrl and scc_dp.
//
// Usage:
//  in_* stream carries requests. A load request (tuser=0) writes one adjacency
//  row; in_tready stays high while idle. A run request (tuser=1) performs
//  Tarjan's SCC search in the single-step search sequencer: root checks,
//  frame scans, successor visits, stack pops and frame returns, each a step.
//  Results then stream out one per node, one per cycle while out_tready is
//  high, out_tlast on the highest node; a stalled receiver holds the sequencer.
//  in_tready is low for the whole run. cfg_* writes node_count; the user must
//  do so only while idle, as the block does not enforce it. Reset: adjacency
//  cleared, node_count = 16, sequencer idle. No clearing pass. A node_count
//  of zero gives a run with no results.
module scc_labeler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] node, [19:4] successors
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] out_node, [7:4] component
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import scc_pkg::*;

  logic [CntW-1:0] node_count_r;
  scc_cmd_t  cmd;
  scc_stat_t stat;
  logic busy, emitting, in_fire;
  logic [NodeW-1:0] res_node, res_comp;
  logic res_last, res_none;

  assign cfg_ready = 1'b1;
  // node count register
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= CntW'(MaxNodes);
    else if (cfg_valid) node_count_r <= cfg_data;
  end

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  scc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_run   (in_tuser == REQ_RUN),
    .out_free (out_tready || res_none),
    .stat, .cmd, .busy, .emitting
  );

  scc_dp u_dp (
    .clk, .rst_n, .cmd,
    .ld_node    (in_tdata[3:0]),
    .ld_row     (in_tdata[19:4]),
    .node_count (node_count_r),
    .stat, .res_node, .res_comp, .res_last, .res_none
  );

  assign out_tvalid = emitting && !res_none;
  assign out_tdata  = {res_comp, res_node};
  assign out_tlast  = res_last;

  // no request taken during a run
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("request accepted while busy");
  // results only after the search
  a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> emitting) else $error("result outside emit");
  // last result returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !busy) else $error("no idle after last");
endmodule

@@ rtl/core/scc_ctrl.sv @@
// scc_ctrl: run sequencer state machine for the SCC labeler.
// Depends on scc_pkg; drives commands into scc_dp.
module scc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_run,
  input  logic              out_free,
  input  scc_pkg::scc_stat_t stat,
  output scc_pkg::scc_cmd_t  cmd,
  output logic              busy,
  output logic              emitting
);
  import scc_pkg::*;

  scc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && in_run) state_nxt = S_START;
      S_START: begin
        if (stat.root_done)     state_nxt = S_EMIT;
        else if (stat.root_new) state_nxt = S_SCAN;
      end
      S_SCAN:  state_nxt = stat.has_child ? S_STEP : (stat.is_head ? S_POP : S_RET);
      S_STEP:  state_nxt = S_SCAN;
      S_POP:   if (stat.pop_last) state_nxt = S_RET;
      S_RET:   state_nxt = stat.frame_empty ? S_START : S_SCAN;
      S_EMIT:  if (out_free && stat.emit_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    emitting = 1'b0;
    case (state_r)
      S_IDLE:  begin
        busy = 1'b0;
        cmd.load = in_fire && !in_run;
        cmd.init = in_fire && in_run;
      end
      S_START: cmd.start = 1'b1;
      S_SCAN:  ;
      S_STEP:  cmd.step = 1'b1;
      S_POP:   cmd.pop = 1'b1;
      S_RET:   cmd.ret = 1'b1;
      S_EMIT:  begin
        emitting = 1'b1;
        cmd.emit = out_free;
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/core/scc_dp.sv @@
// scc_dp: adjacency store, Tarjan stacks and label store.
// Depends on scc_pkg; steered by scc_ctrl commands.
module scc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scc_pkg::scc_cmd_t           cmd,
  input  logic [scc_pkg::NodeW-1:0]   ld_node,
  input  logic [scc_pkg::MaxNodes-1:0] ld_row,
  input  logic [scc_pkg::CntW-1:0]    node_count,
  output scc_pkg::scc_stat_t          stat,
  output logic [scc_pkg::NodeW-1:0]   res_node,
  output logic [scc_pkg::NodeW-1:0]   res_comp,
  output logic                        res_last,
  output logic                        res_none
);
  import scc_pkg::*;

  logic [MaxNodes-1:0] adj_r [MaxNodes];
  logic [CntW-1:0]     ord_r [MaxNodes];
  logic [CntW-1:0]     low_r [MaxNodes];
  logic [NodeW-1:0]    lab_r [MaxNodes];
  logic [NodeW-1:0]    nstk_r [MaxNodes];
  logic [NodeW-1:0]    fnode_r [MaxNodes];
  logic [CntW-1:0]     fptr_r [MaxNodes];
  logic [MaxNodes-1:0] vis_r, onst_r, used_r;
  logic [CntW-1:0]     n_r, root_r, sp_r, fp_r, order_r, emit_r;
  logic [NodeW-1:0]    comp_r;

  logic [NodeW-1:0] top, child, popw, par;
  logic [CntW-1:0]  ptr;
  logic [MaxNodes-1:0] cand;
  logic             found;
  logic [CntW-1:0]  nclip;

  assign nclip = (node_count > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_count;
  assign top  = fnode_r[fp_r[NodeW-1:0] - NodeW'(1)];
  assign ptr  = fptr_r[fp_r[NodeW-1:0] - NodeW'(1)];
  assign par  = fnode_r[fp_r[NodeW-1:0] - NodeW'(2)];
  assign popw = nstk_r[sp_r[NodeW-1:0] - NodeW'(1)];

  // lowest successor at or above ptr
  always_comb begin
    cand  = adj_r[top] & used_r;
    found = 1'b0;
    child = '0;
    for (int j = MaxNodes - 1; j >= 0; j--) begin
      if (cand[j] && CntW'(j) >= ptr) begin
        found = 1'b1;
        child = NodeW'(j);
      end
    end
  end

  assign stat.root_done   = root_r >= n_r;
  assign stat.root_new    = !vis_r[root_r[NodeW-1:0]];
  assign stat.has_child   = found;
  assign stat.is_head     = low_r[top] == ord_r[top];
  assign stat.pop_last    = popw == top;
  assign stat.frame_empty = fp_r == CntW'(1);
  // an empty run ends its emit phase at once
  assign stat.emit_last   = res_none || (emit_r == n_r - CntW'(1));

  assign res_node = emit_r[NodeW-1:0];
  assign res_comp = lab_r[emit_r[NodeW-1:0]];
  assign res_last = stat.emit_last;
  assign res_none = n_r == '0;

  // adjacency store, reset to no edges
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxNodes; i++) adj_r[i] <= '0;
    end else if (cmd.load) begin
      adj_r[ld_node] <= ld_row;
    end
  end

  // search control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= '0; onst_r <= '0; sp_r <= '0; fp_r <= '0;
      root_r <= '0; order_r <= '0; comp_r <= '0; emit_r <= '0;
      n_r <= '0; used_r <= '0;
    end else begin
      if (cmd.init) begin
        n_r <= nclip;
        used_r <= MaxNodes'((32'd1 << nclip) - 32'd1);
        vis_r <= '0; onst_r <= '0; sp_r <= '0; fp_r <= '0;
        root_r <= '0; order_r <= '0; comp_r <= '0; emit_r <= '0;
      end
      if (cmd.start) begin
        if (root_r < n_r) begin
          if (!vis_r[root_r[NodeW-1:0]]) begin
            fnode_r[0] <= root_r[NodeW-1:0];
            fptr_r[0]  <= '0;
            fp_r <= CntW'(1);
            ord_r[root_r[NodeW-1:0]] <= order_r;
            low_r[root_r[NodeW-1:0]] <= order_r;
            nstk_r[sp_r[NodeW-1:0]] <= root_r[NodeW-1:0];
            sp_r <= sp_r + CntW'(1);
            order_r <= order_r + CntW'(1);
            vis_r[root_r[NodeW-1:0]]  <= 1'b1;
            onst_r[root_r[NodeW-1:0]] <= 1'b1;
          end
          root_r <= root_r + CntW'(1);
        end
      end
      if (cmd.step) begin
        fptr_r[fp_r[NodeW-1:0] - NodeW'(1)] <= CntW'(child) + CntW'(1);
        if (!vis_r[child]) begin
          fnode_r[fp_r[NodeW-1:0]] <= child;
          fptr_r[fp_r[NodeW-1:0]]  <= '0;
          fp_r <= fp_r + CntW'(1);
          ord_r[child] <= order_r;
          low_r[child] <= order_r;
          nstk_r[sp_r[NodeW-1:0]] <= child;
          sp_r <= sp_r + CntW'(1);
          order_r <= order_r + CntW'(1);
          vis_r[child]  <= 1'b1;
          onst_r[child] <= 1'b1;
        end else if (onst_r[child] && ord_r[child] < low_r[top]) begin
          low_r[top] <= ord_r[child];
        end
      end
      if (cmd.pop) begin
        sp_r <= sp_r - CntW'(1);
        onst_r[popw] <= 1'b0;
        lab_r[popw]  <= comp_r;
        if (popw == top) comp_r <= comp_r + NodeW'(1);
      end
      if (cmd.ret) begin
        fp_r <= fp_r - CntW'(1);
        if (fp_r > CntW'(1) && low_r[top] < low_r[par]) low_r[par] <= low_r[top];
      end
      if (cmd.emit) emit_r <= emit_r + CntW'(1);
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for scc_labeler_unit (strongly connected component labeling).
// Depends on scc_pkg and the scc_labeler_unit RTL; predicts labels with its own Tarjan search.
`timescale 1ns / 100ps

module testbench;
  import scc_pkg::*;

  typedef struct packed {
    logic [3:0] node;
    logic [3:0] component;
    logic       last;
  } label_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  // predictor state
  logic [15:0] graph_rows [MaxNodes];
  logic [4:0]  nodes_in_use;
  label_t      label_queue [$];

  int errors;
  int labels_seen;
  int runs_sent;
  int loads_sent;
  bit stall_ready;

  scc_labeler_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // iterative Tarjan over the in-use nodes; queues one label per node
  task automatic predict_labels();
    int n, order, comp, sp, fp, c, top, ptr, par, w;
    logic [15:0] used, row, seen, onstk;
    int vis [16];
    int low [16];
    int nstk [16];
    int ftop [16];
    int fptr [16];
    int lab [16];
    label_t pred;
    n = (nodes_in_use > 16) ? 16 : nodes_in_use;
    if (n == 0) return;
    used = (n == 16) ? 16'hFFFF : ((16'h1 << n) - 16'h1);
    seen = '0; onstk = '0; order = 0; comp = 0; sp = 0; fp = 0;
    for (int i = 0; i < 16; i++) lab[i] = 0;
    for (int v = 0; v < n; v++) begin
      if (seen[v]) continue;
      ftop[fp] = v; fptr[fp] = 0; fp++;
      vis[v] = order; low[v] = order; order++;
      nstk[sp] = v; sp++; seen[v] = 1'b1; onstk[v] = 1'b1;
      while (fp > 0) begin
        top = ftop[fp-1];
        ptr = fptr[fp-1];
        row = graph_rows[top] & used;
        c = ptr;
        while (c < n && !row[c]) c++;
        if (c < n) begin
          fptr[fp-1] = c + 1;
          if (!seen[c]) begin
            ftop[fp] = c; fptr[fp] = 0; fp++;
            vis[c] = order; low[c] = order; order++;
            nstk[sp] = c; sp++; seen[c] = 1'b1; onstk[c] = 1'b1;
          end else if (onstk[c]) begin
            if (vis[c] < low[top]) low[top] = vis[c];
          end
        end else begin
          if (low[top] == vis[top]) begin
            do begin
              sp--;
              w = nstk[sp];
              onstk[w] = 1'b0;
              lab[w] = comp & 15;
            end while (w != top && sp > 0);
            comp++;
          end
          fp--;
          if (fp > 0) begin
            par = ftop[fp-1];
            if (low[top] < low[par]) low[par] = low[top];
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      pred = '{node: i[3:0], component: lab[i][3:0], last: (i == n - 1)};
      label_queue.insert(label_queue.size(), pred);
    end
  endtask

  // send one request and update the prediction when it is accepted
  task automatic send_request(req_type_t kind, logic [3:0] nd, logic [15:0] succ);
    repeat (1 + short_gap()) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'h0, succ, nd};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    if (kind == REQ_LOAD) begin
      graph_rows[nd] = succ;
      loads_sent++;
    end else begin
      predict_labels();
      runs_sent++;
    end
  endtask

  task automatic wait_drained();
    while (label_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_node_count(logic [4:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    nodes_in_use = value;
  endtask

  task automatic load_random_graph(int n, int density);
    for (int i = 0; i < n; i++) begin
      logic [15:0] r;
      r = '0;
      for (int j = 0; j < 16; j++) r[j] = ($urandom_range(0, 99) < density);
      send_request(REQ_LOAD, i[3:0], r);
    end
  endtask

  // result checker with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        label_t exp_lab;
        labels_seen++;
        if (label_queue.size() == 0) begin
          $error("unexpected result node=%0d", out_tdata[3:0]);
          errors++;
        end else begin
          exp_lab = label_queue.pop_front();
          if (out_tdata[3:0] !== exp_lab.node) begin
            $error("out_node expected %0d actual %0d", exp_lab.node, out_tdata[3:0]);
            errors++;
          end
          if (out_tdata[7:4] !== exp_lab.component) begin
            $error("component expected %0d actual %0d", exp_lab.component, out_tdata[7:4]);
            errors++;
          end
          if (out_tlast !== exp_lab.last) begin
            $error("last expected %0d actual %0d", exp_lab.last, out_tlast);
            errors++;
          end
        end
      end
      if (stall_ready) out_tready <= ($urandom_range(0, 9) < 4);
      else out_tready <= 1'b1;
    end
  end

  // edge cases: empty graph, extremes of the fields, self loops, one big cycle
  task automatic test_directed();
    send_request(REQ_RUN, 4'hF, 16'hFFFF);             // no edges, all singletons
    send_request(REQ_LOAD, 4'h0, 16'h0001);            // self loop
    send_request(REQ_LOAD, 4'hF, 16'h0001);
    send_request(REQ_LOAD, 4'h1, 16'hFFFF);
    send_request(REQ_RUN, 4'h0, 16'h0000);
    for (int i = 0; i < 16; i++)                       // ring through every node
      send_request(REQ_LOAD, i[3:0], 16'h1 << ((i + 1) % 16));
    send_request(REQ_RUN, 4'h5, 16'h5A5A);
    send_request(REQ_LOAD, 4'h2, 16'h0000);            // break ring
    send_request(REQ_RUN, 4'h0, 16'h0000);
  endtask

  // node count extremes, including zero and values above the node limit
  task automatic test_node_count();
    write_node_count(5'd1);
    send_request(REQ_RUN, 4'h0, 16'h0);
    write_node_count(5'd0);
    send_request(REQ_RUN, 4'h0, 16'h0);
    write_node_count(5'd31);
    send_request(REQ_RUN, 4'h0, 16'h0);
    write_node_count(5'd3);                            // edges above count ignored
    send_request(REQ_LOAD, 4'h0, 16'hFFF2);
    send_request(REQ_LOAD, 4'h1, 16'h8001);
    send_request(REQ_RUN, 4'h0, 16'h0);
    write_node_count(5'd16);
  endtask

  // random graphs at several sizes and densities
  task automatic test_random_graphs();
    int count;
    stall_ready = 1'b1;
    while (loads_sent + runs_sent < 115) begin
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 31) : $urandom_range(2, 8);
      write_node_count(count[4:0]);
      load_random_graph((count > 16) ? 16 : count, $urandom_range(5, 50));
      send_request(REQ_RUN, 4'($urandom), 16'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        send_request(REQ_LOAD, 4'($urandom), 16'($urandom));     // noise row
        send_request(REQ_RUN, 4'($urandom), 16'($urandom));
      end
    end
    stall_ready = 1'b0;
  endtask

  initial begin
    errors = 0; labels_seen = 0; runs_sent = 0; loads_sent = 0;
    stall_ready = 1'b0;
    nodes_in_use = 5'd16;
    for (int i = 0; i < MaxNodes; i++) graph_rows[i] = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_node_count();
    test_random_graphs();
    wait_drained();
    $display("covered %0d row loads and %0d labeling runs, %0d labels checked",
             loads_sent, runs_sent, labels_seen);
    if (errors == 0 && label_queue.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
